// ===== hw/rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, register codes and the back-end program of the ray/triangle
// intersection unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  typedef enum logic [2:0] {
    CFG_DIR_X,
    CFG_DIR_Y,
    CFG_DIR_Z,
    CFG_ORG_X,
    CFG_ORG_Y,
    CFG_ORG_Z,
    CFG_MAX_DIST
  } cfg_idx_t;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic        [30:0] max_dist;
  } cfg_t;

  // one queued triangle: first vertex, edges, origin offset and ray flag
  typedef struct packed {
    logic [2:0][31:0] v1;
    logic [2:0][31:0] e1;
    logic [2:0][31:0] e2;
    logic [2:0][31:0] tv;
    logic             start;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      distance;
    logic [16:0]      bary_u;
    logic [16:0]      bary_v;
    logic [2:0][17:0] nrm;
    logic [2:0][31:0] pt;
  } res_t;

  typedef enum logic [5:0] {
    R_ZERO,
    R_D0, R_D1, R_D2,
    R_E10, R_E11, R_E12,
    R_E20, R_E21, R_E22,
    R_TV0, R_TV1, R_TV2,
    R_P0, R_P1, R_P2,
    R_Q0, R_Q1, R_Q2,
    R_N0, R_N1, R_N2,
    R_V10, R_V11, R_V12,
    R_DET, R_NUM, R_U, R_V, R_T, R_LEN, R_SQ,
    R_NM0, R_NM1, R_NM2,
    R_PT0, R_PT1, R_PT2
  } reg_t;

  typedef enum logic [2:0] {
    OP_MAC,
    OP_DIV,
    OP_SQRT,
    OP_CHK_DET,
    OP_CHK_U,
    OP_CHK_V,
    OP_CHK_T,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t  op;
    reg_t a;
    reg_t b;
    reg_t c;
    reg_t dst;
    logic first;
    logic last;
    logic neg;
    logic sq;
  } instr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ACC,
    S_DIV,
    S_DFIN,
    S_SQRT,
    S_OUT
  } st_t;

  function automatic logic [31:0] sat_sub(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'sh0_7FFF_FFFF)       sat_sub = 32'h7FFF_FFFF;
    else if (d < -33'sh0_8000_0000) sat_sub = 32'h8000_0000;
    else                            sat_sub = d[31:0];
  endfunction

  function automatic instr_t mac(reg_t a, reg_t b, logic first, logic last, logic neg,
                                 reg_t dst, reg_t c, logic sq);
    instr_t i;
    i.op = OP_MAC; i.a = a; i.b = b; i.c = c; i.dst = dst;
    i.first = first; i.last = last; i.neg = neg; i.sq = sq;
    return i;
  endfunction

  function automatic instr_t ctl(op_t op, reg_t a, reg_t b, reg_t dst);
    instr_t i;
    i.op = op; i.a = a; i.b = b; i.c = R_ZERO; i.dst = dst;
    i.first = 1'b0; i.last = 1'b0; i.neg = 1'b0; i.sq = 1'b0;
    return i;
  endfunction

  // back-end program: one product, division, root or test per entry, then done
  function automatic instr_t prog(logic [5:0] pc);
    case (pc)
      6'd0:  prog = mac(R_D1,  R_E22, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd1:  prog = mac(R_D2,  R_E21, 1'b0, 1'b1, 1'b1, R_P0,   R_ZERO, 1'b0);
      6'd2:  prog = mac(R_D2,  R_E20, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd3:  prog = mac(R_D0,  R_E22, 1'b0, 1'b1, 1'b1, R_P1,   R_ZERO, 1'b0);
      6'd4:  prog = mac(R_D0,  R_E21, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd5:  prog = mac(R_D1,  R_E20, 1'b0, 1'b1, 1'b1, R_P2,   R_ZERO, 1'b0);
      6'd6:  prog = mac(R_E10, R_P0,  1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd7:  prog = mac(R_E11, R_P1,  1'b0, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd8:  prog = mac(R_E12, R_P2,  1'b0, 1'b1, 1'b0, R_DET,  R_ZERO, 1'b0);
      6'd9:  prog = ctl(OP_CHK_DET, R_ZERO, R_ZERO, R_ZERO);
      6'd10: prog = mac(R_TV0, R_P0,  1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd11: prog = mac(R_TV1, R_P1,  1'b0, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd12: prog = mac(R_TV2, R_P2,  1'b0, 1'b1, 1'b0, R_NUM,  R_ZERO, 1'b0);
      6'd13: prog = ctl(OP_DIV, R_NUM, R_DET, R_U);
      6'd14: prog = ctl(OP_CHK_U, R_ZERO, R_ZERO, R_ZERO);
      6'd15: prog = mac(R_TV1, R_E12, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd16: prog = mac(R_TV2, R_E11, 1'b0, 1'b1, 1'b1, R_Q0,   R_ZERO, 1'b0);
      6'd17: prog = mac(R_TV2, R_E10, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd18: prog = mac(R_TV0, R_E12, 1'b0, 1'b1, 1'b1, R_Q1,   R_ZERO, 1'b0);
      6'd19: prog = mac(R_TV0, R_E11, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd20: prog = mac(R_TV1, R_E10, 1'b0, 1'b1, 1'b1, R_Q2,   R_ZERO, 1'b0);
      6'd21: prog = mac(R_D0,  R_Q0,  1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd22: prog = mac(R_D1,  R_Q1,  1'b0, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd23: prog = mac(R_D2,  R_Q2,  1'b0, 1'b1, 1'b0, R_NUM,  R_ZERO, 1'b0);
      6'd24: prog = ctl(OP_DIV, R_NUM, R_DET, R_V);
      6'd25: prog = ctl(OP_CHK_V, R_ZERO, R_ZERO, R_ZERO);
      6'd26: prog = mac(R_E20, R_Q0,  1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd27: prog = mac(R_E21, R_Q1,  1'b0, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd28: prog = mac(R_E22, R_Q2,  1'b0, 1'b1, 1'b0, R_NUM,  R_ZERO, 1'b0);
      6'd29: prog = ctl(OP_DIV, R_NUM, R_DET, R_T);
      6'd30: prog = ctl(OP_CHK_T, R_ZERO, R_ZERO, R_ZERO);
      6'd31: prog = mac(R_E11, R_E22, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd32: prog = mac(R_E12, R_E21, 1'b0, 1'b1, 1'b1, R_N0,   R_ZERO, 1'b0);
      6'd33: prog = mac(R_E12, R_E20, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd34: prog = mac(R_E10, R_E22, 1'b0, 1'b1, 1'b1, R_N1,   R_ZERO, 1'b0);
      6'd35: prog = mac(R_E10, R_E21, 1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b0);
      6'd36: prog = mac(R_E11, R_E20, 1'b0, 1'b1, 1'b1, R_N2,   R_ZERO, 1'b0);
      6'd37: prog = mac(R_N0,  R_N0,  1'b1, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b1);
      6'd38: prog = mac(R_N1,  R_N1,  1'b0, 1'b0, 1'b0, R_ZERO, R_ZERO, 1'b1);
      6'd39: prog = mac(R_N2,  R_N2,  1'b0, 1'b1, 1'b0, R_SQ,   R_ZERO, 1'b1);
      6'd40: prog = ctl(OP_SQRT, R_SQ, R_ZERO, R_LEN);
      6'd41: prog = ctl(OP_DIV, R_N0, R_LEN, R_NM0);
      6'd42: prog = ctl(OP_DIV, R_N1, R_LEN, R_NM1);
      6'd43: prog = ctl(OP_DIV, R_N2, R_LEN, R_NM2);
      6'd44: prog = mac(R_U,   R_E10, 1'b1, 1'b0, 1'b0, R_ZERO, R_V10,  1'b0);
      6'd45: prog = mac(R_V,   R_E20, 1'b0, 1'b1, 1'b0, R_PT0,  R_ZERO, 1'b0);
      6'd46: prog = mac(R_U,   R_E11, 1'b1, 1'b0, 1'b0, R_ZERO, R_V11,  1'b0);
      6'd47: prog = mac(R_V,   R_E21, 1'b0, 1'b1, 1'b0, R_PT1,  R_ZERO, 1'b0);
      6'd48: prog = mac(R_U,   R_E12, 1'b1, 1'b0, 1'b0, R_ZERO, R_V12,  1'b0);
      6'd49: prog = mac(R_V,   R_E22, 1'b0, 1'b1, 1'b0, R_PT2,  R_ZERO, 1'b0);
      default: prog = ctl(OP_DONE, R_ZERO, R_ZERO, R_ZERO);
    endcase
  endfunction

endpackage

// ===== hw/rtl/ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Tests one configured ray against a stream of triangles, one result beat
// per triangle.
// ----------------------------------------------------------------------------
// A hit runs the whole back-end program; misses end at the failing test.
// The back end starts a new triangle only once the last one is done, held
// up by the bit-serial divider and root; a two-deep queue keeps accepting
// meanwhile.
// Reset: synchronous, resets the queue, ray registers and closest distance.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex1_x, vertex1_y, vertex1_z, vertex2_x .. vertex3_z (32 bits each)
  input  logic [287:0] s_axis_tdata,
  // start_of_ray
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance, bary_u, bary_v, normal_x/y/z, point_x/y/z, one pad bit
  output logic [215:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);

  cfg_t  cfg;
  item_t f_item, q_head;
  logic  q_push, q_full, q_pop, q_valid;
  res_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir_x    <= '0;
      cfg.dir_y    <= '0;
      cfg.dir_z    <= -18'sd65536;
      cfg.org_x    <= '0;
      cfg.org_y    <= '0;
      cfg.org_z    <= '0;
      cfg.max_dist <= 31'h7FFF_FFFF;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIR_X:    cfg.dir_x    <= cfg_data[17:0];
        CFG_DIR_Y:    cfg.dir_y    <= cfg_data[17:0];
        CFG_DIR_Z:    cfg.dir_z    <= cfg_data[17:0];
        CFG_ORG_X:    cfg.org_x    <= cfg_data;
        CFG_ORG_Y:    cfg.org_y    <= cfg_data;
        CFG_ORG_Z:    cfg.org_z    <= cfg_data;
        CFG_MAX_DIST: cfg.max_dist <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  rti_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (f_item)
  );

  rti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  rti_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tuser = res.hit;
  assign m_axis_tdata = {1'b0, res.pt[2], res.pt[1], res.pt[0],
                         res.nrm[2], res.nrm[1], res.nrm[0],
                         res.bary_v, res.bary_u, res.distance};

endmodule

// ===== hw/rtl/rti_front.sv =====
// ----------------------------------------------------------------------------
// rti_front
// Takes triangle beats, forms the saturated edges and origin offset, and
// hands them to the queue.
// ----------------------------------------------------------------------------
module rti_front
  import rti_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         q_full,
  output logic         q_push,
  output item_t        q_item
);

  logic [2:0][31:0] v1, v2, v3, org;
  logic             busy;

  assign v1  = s_axis_tdata[95:0];
  assign v2  = s_axis_tdata[191:96];
  assign v3  = s_axis_tdata[287:192];
  assign org = {cfg.org_z, cfg.org_y, cfg.org_x};

  // hold off after reset while the busy register is still set, so the queue settles
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign s_axis_tready = !q_full && !busy;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_item       = '0;
    q_item.v1    = v1;
    q_item.start = s_axis_tuser;
    for (int i = 0; i < 3; i++) begin
      q_item.e1[i] = sat_sub(v2[i], v1[i]);
      q_item.e2[i] = sat_sub(v3[i], v1[i]);
      q_item.tv[i] = sat_sub(org[i], v1[i]);
    end
  end

endmodule

// ===== hw/rtl/rti_queue.sv =====
// ----------------------------------------------------------------------------
// rti_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rti_queue
  import rti_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  item_t             mem [QDEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [AW:0]       count;

  assign full  = (count == (AW+1)'(QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/rti_back.sv =====
// ----------------------------------------------------------------------------
// rti_back
// Runs the intersection program on one queued triangle: a shared multiplier
// with accumulator, a bit-serial divider and a bit-pair square root.
// ----------------------------------------------------------------------------
module rti_back
  import rti_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_head,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int  NB      = 32 + FRAC_BITS;
  localparam int  CW      = $clog2(NB);
  localparam longint EPS_RAW = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam logic signed [32:0] EPS = (EPS_RAW < 1) ? 33'sd1 : 33'(EPS_RAW);
  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  st_t  state, state_next;
  logic [5:0] pc;
  instr_t ins;

  logic signed [31:0] e1 [3], e2 [3], tv [3], v1 [3], p [3], q [3], n [3];
  logic signed [31:0] nm [3], pt [3];
  logic signed [31:0] det, num, u, v, t;
  logic        [31:0] len;
  logic        [63:0] sq;
  logic        [30:0] closest;
  logic               hit;

  logic signed [65:0] prod, acc, term, acc_new;
  logic signed [32:0] opa, opb, opc;

  logic [NB-1:0] dvd;
  logic [32:0]   rem, dvs;
  logic [33:0]   trial;
  logic          negq;
  logic [CW-1:0] dcnt;
  logic signed [31:0] dres;

  logic [63:0] sx, sr, sb, sr_next, sx_next;
  logic [64:0] ssum;
  logic [4:0]  scnt;

  logic        wr_en;
  logic signed [31:0] wr_val;
  logic        chk_fail, load_out;

  assign ins = prog(pc);

  function automatic logic signed [32:0] sel(reg_t r);
    case (r)
      R_D0:  sel = 33'(cfg.dir_x);
      R_D1:  sel = 33'(cfg.dir_y);
      R_D2:  sel = 33'(cfg.dir_z);
      R_E10: sel = 33'(e1[0]);
      R_E11: sel = 33'(e1[1]);
      R_E12: sel = 33'(e1[2]);
      R_E20: sel = 33'(e2[0]);
      R_E21: sel = 33'(e2[1]);
      R_E22: sel = 33'(e2[2]);
      R_TV0: sel = 33'(tv[0]);
      R_TV1: sel = 33'(tv[1]);
      R_TV2: sel = 33'(tv[2]);
      R_P0:  sel = 33'(p[0]);
      R_P1:  sel = 33'(p[1]);
      R_P2:  sel = 33'(p[2]);
      R_Q0:  sel = 33'(q[0]);
      R_Q1:  sel = 33'(q[1]);
      R_Q2:  sel = 33'(q[2]);
      R_N0:  sel = 33'(n[0]);
      R_N1:  sel = 33'(n[1]);
      R_N2:  sel = 33'(n[2]);
      R_V10: sel = 33'(v1[0]);
      R_V11: sel = 33'(v1[1]);
      R_V12: sel = 33'(v1[2]);
      R_DET: sel = 33'(det);
      R_NUM: sel = 33'(num);
      R_U:   sel = 33'(u);
      R_V:   sel = 33'(v);
      R_T:   sel = 33'(t);
      R_LEN: sel = $signed({1'b0, len});
      default: sel = '0;
    endcase
  endfunction

  always_comb begin
    opa = sel(ins.a);
    opb = sel(ins.b);
    opc = sel(ins.c);
  end

  // accumulate: square sums stay exact, other products drop FRAC_BITS
  always_comb begin
    term    = ins.sq ? prod : (prod >>> FRAC_BITS);
    acc_new = (ins.first ? 66'(opc) : acc) + (ins.neg ? -term : term);
  end

  // divider step and final sign/saturation
  always_comb begin
    trial = {rem, dvd[NB-1]} - {1'b0, dvs};
    if (dvs == '0) begin
      dres = '0;
    end else if (negq) begin
      dres = (dvd > NB'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(dvd[31:0]);
    end else begin
      dres = (dvd > NB'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(dvd[31:0]);
    end
  end

  // square-root step
  always_comb begin
    ssum = {1'b0, sr} + {1'b0, sb};
    if ({1'b0, sx} >= ssum) begin
      sx_next = sx - ssum[63:0];
      sr_next = (sr >> 1) + sb;
    end else begin
      sx_next = sx;
      sr_next = sr >> 1;
    end
  end

  always_comb begin
    chk_fail = 1'b0;
    case (ins.op)
      OP_CHK_DET: chk_fail = (33'(det) < EPS) && (33'(det) > -EPS);
      OP_CHK_U:   chk_fail = (u < 0) || (34'(u) > ONE);
      OP_CHK_V:   chk_fail = (v < 0) || ((34'(u) + 34'(v)) > ONE);
      OP_CHK_T:   chk_fail = (t > $signed({1'b0, closest})) || (33'(t) < EPS);
      default:    chk_fail = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_EXEC;
      S_EXEC: begin
        case (ins.op)
          OP_MAC:  state_next = S_ACC;
          OP_DIV:  state_next = S_DIV;
          OP_SQRT: state_next = S_SQRT;
          OP_DONE: state_next = S_OUT;
          default: if (chk_fail) state_next = S_OUT;
        endcase
      end
      S_ACC:  state_next = S_EXEC;
      S_DIV:  if (dcnt == CW'(NB - 1)) state_next = S_DFIN;
      S_DFIN: state_next = S_EXEC;
      S_SQRT: if (scnt == 5'd31) state_next = S_EXEC;
      S_OUT:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = (state == S_IDLE) && q_valid;
    load_out = (state == S_OUT) && (!out_valid || out_ready);
    wr_en    = 1'b0;
    wr_val   = '0;
    case (state)
      S_ACC: begin
        wr_en = ins.last && !ins.sq;
        if (acc_new > 66'sh0_7FFF_FFFF)       wr_val = 32'sh7FFF_FFFF;
        else if (acc_new < -66'sh0_8000_0000) wr_val = 32'sh8000_0000;
        else                                  wr_val = acc_new[31:0];
      end
      S_DFIN: begin
        wr_en  = 1'b1;
        wr_val = dres;
      end
      S_SQRT: begin
        wr_en  = (scnt == 5'd31);
        wr_val = sr_next[31:0];
      end
      default: begin
        wr_en  = 1'b0;
        wr_val = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      closest   <= 31'h7FFF_FFFF;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && q_head.start) begin
        closest <= cfg.max_dist;
      end
      if (state == S_EXEC && ins.op == OP_CHK_T && !chk_fail) begin
        closest <= t[30:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pc  <= '0;
        hit <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          e1[i] <= q_head.e1[i];
          e2[i] <= q_head.e2[i];
          tv[i] <= q_head.tv[i];
          v1[i] <= q_head.v1[i];
        end
      end
      S_EXEC: begin
        case (ins.op)
          OP_MAC: prod <= opa * opb;
          OP_DIV: begin
            dvd  <= {(opa[32] ? 32'(-opa) : opa[31:0]), {FRAC_BITS{1'b0}}};
            dvs  <= opb[32] ? 33'(-opb) : 33'(opb);
            negq <= opa[32] ^ opb[32];
            rem  <= '0;
            dcnt <= '0;
          end
          OP_SQRT: begin
            sx   <= sq;
            sr   <= '0;
            sb   <= 64'd1 << 62;
            scnt <= '0;
          end
          OP_DONE: hit <= 1'b1;
          default: if (!chk_fail) pc <= pc + 1'b1;
        endcase
      end
      S_ACC: begin
        acc <= acc_new;
        if (ins.last && ins.sq) begin
          sq <= acc_new[63:0];
        end
        pc <= pc + 1'b1;
      end
      S_DIV: begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          dvd <= {dvd[NB-2:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dvd[NB-1]};
          dvd <= {dvd[NB-2:0], 1'b0};
        end
        dcnt <= dcnt + 1'b1;
      end
      S_DFIN: pc <= pc + 1'b1;
      S_SQRT: begin
        sx   <= sx_next;
        sr   <= sr_next;
        sb   <= sb >> 2;
        scnt <= scnt + 1'b1;
        if (scnt == 5'd31) begin
          pc <= pc + 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (wr_en) begin
      case (ins.dst)
        R_P0:  p[0]  <= wr_val;
        R_P1:  p[1]  <= wr_val;
        R_P2:  p[2]  <= wr_val;
        R_Q0:  q[0]  <= wr_val;
        R_Q1:  q[1]  <= wr_val;
        R_Q2:  q[2]  <= wr_val;
        R_N0:  n[0]  <= wr_val;
        R_N1:  n[1]  <= wr_val;
        R_N2:  n[2]  <= wr_val;
        R_DET: det   <= wr_val;
        R_NUM: num   <= wr_val;
        R_U:   u     <= wr_val;
        R_V:   v     <= wr_val;
        R_T:   t     <= wr_val;
        R_LEN: len   <= wr_val;
        R_NM0: nm[0] <= wr_val;
        R_NM1: nm[1] <= wr_val;
        R_NM2: nm[2] <= wr_val;
        R_PT0: pt[0] <= wr_val;
        R_PT1: pt[1] <= wr_val;
        R_PT2: pt[2] <= wr_val;
        default: begin
        end
      endcase
    end

    if (load_out) begin
      out_res <= '0;
      if (hit) begin
        out_res.hit      <= 1'b1;
        out_res.distance <= t[30:0];
        out_res.bary_u   <= u[16:0];
        out_res.bary_v   <= v[16:0];
        for (int i = 0; i < 3; i++) begin
          out_res.nrm[i] <= nm[i][17:0];
          out_res.pt[i]  <= pt[i];
        end
      end
    end
  end

endmodule

// ===== tb/sv/rti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// Watches the ray, triangle and result channels of the intersection unit,
// works out the expected hit record of each triangle beat and compares every
// result beat, field by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module rti_checker
  import rti_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [215:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           errors,
  output int           pending
);

  localparam int     FRAC = 16;
  localparam longint ONE  = 64'sd1 << FRAC;
  localparam longint EPS  = ((ONE + 500000) / 1000000) < 1 ? 1 : (ONE + 500000) / 1000000;

  logic signed [17:0] ray_dir [3];
  logic signed [31:0] ray_org [3];
  logic [30:0]        max_dist;
  logic [30:0]        closest;
  res_t               hit_q [$];

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // arithmetic shift of a signed longint rounds toward minus infinity
  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint divq(longint n, longint d);
    return sat32((n * ONE) / d);
  endfunction

  function automatic void cross3(input longint a [3], input longint b [3],
                                 output longint r [3]);
    r[0] = sat32(mulq(a[1], b[2]) - mulq(a[2], b[1]));
    r[1] = sat32(mulq(a[2], b[0]) - mulq(a[0], b[2]));
    r[2] = sat32(mulq(a[0], b[1]) - mulq(a[1], b[0]));
  endfunction

  function automatic longint dot3(input longint a [3], input longint b [3]);
    return sat32(mulq(a[0], b[0]) + mulq(a[1], b[1]) + mulq(a[2], b[2]));
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // updates the closest distance of the current ray as a side effect
  function automatic res_t trace_triangle(logic [287:0] d, logic sor);
    longint v1 [3], v2 [3], v3 [3], dv [3], ov [3];
    longint e1 [3], e2 [3], tv [3], p [3], q [3], n [3];
    longint det, u, v, t, c;
    bit [63:0] sq, len;
    res_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      v1[i] = longint'($signed(d[32*i +: 32]));
      v2[i] = longint'($signed(d[96 + 32*i +: 32]));
      v3[i] = longint'($signed(d[192 + 32*i +: 32]));
      dv[i] = longint'(ray_dir[i]);
      ov[i] = longint'(ray_org[i]);
      e1[i] = sat32(v2[i] - v1[i]);
      e2[i] = sat32(v3[i] - v1[i]);
      tv[i] = sat32(ov[i] - v1[i]);
    end
    if (sor) closest = max_dist;
    cross3(dv, e2, p);
    det = dot3(e1, p);
    if (det < EPS && det > -EPS) return r;
    u = divq(dot3(tv, p), det);
    if (u < 0 || u > ONE) return r;
    cross3(tv, e1, q);
    v = divq(dot3(dv, q), det);
    if (v < 0 || u + v > ONE) return r;
    t = divq(dot3(e2, q), det);
    if (t > longint'(closest) || t < EPS) return r;
    closest = t[30:0];
    cross3(e1, e2, n);
    sq = 64'(n[0] * n[0]) + 64'(n[1] * n[1]) + 64'(n[2] * n[2]);
    len = int_sqrt(sq);
    r.hit = 1'b1;
    r.distance = t[30:0];
    r.bary_u = u[16:0];
    r.bary_v = v[16:0];
    for (int i = 0; i < 3; i++) begin
      c = (len != 0) ? (n[i] * ONE) / $signed(len) : 0;
      r.nrm[i] = c[17:0];
      c = sat32(v1[i] + mulq(u, e1[i]) + mulq(v, e2[i]));
      r.pt[i] = c[31:0];
    end
    return r;
  endfunction

  function automatic int field_diff(string f, longint e, longint a);
    if (e == a) return 0;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, f, e, a);
    return 1;
  endfunction

  always @(posedge clk) begin
    int   nerr;
    res_t got, want;
    nerr = 0;
    if (rst) begin
      ray_dir[0] = '0; ray_dir[1] = '0; ray_dir[2] = -18'sd65536;
      ray_org[0] = '0; ray_org[1] = '0; ray_org[2] = '0;
      max_dist = 31'h7FFF_FFFF;
      closest = 31'h7FFF_FFFF;
      hit_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIR_X:    ray_dir[0] = cfg_data[17:0];
          CFG_DIR_Y:    ray_dir[1] = cfg_data[17:0];
          CFG_DIR_Z:    ray_dir[2] = cfg_data[17:0];
          CFG_ORG_X:    ray_org[0] = cfg_data;
          CFG_ORG_Y:    ray_org[1] = cfg_data;
          CFG_ORG_Z:    ray_org[2] = cfg_data;
          CFG_MAX_DIST: max_dist = cfg_data[30:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        hit_q.push_back(trace_triangle(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit = m_axis_tuser;
        got.distance = m_axis_tdata[30:0];
        got.bary_u = m_axis_tdata[47:31];
        got.bary_v = m_axis_tdata[64:48];
        for (int i = 0; i < 3; i++) begin
          got.nrm[i] = m_axis_tdata[65 + 18*i +: 18];
          got.pt[i] = m_axis_tdata[119 + 32*i +: 32];
        end
        if (hit_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %0h", $time, got);
          nerr = 1;
        end else begin
          want = hit_q.pop_front();
          nerr += field_diff("hit", want.hit, got.hit);
          nerr += field_diff("distance", want.distance, got.distance);
          nerr += field_diff("bary_u", want.bary_u, got.bary_u);
          nerr += field_diff("bary_v", want.bary_v, got.bary_v);
          for (int i = 0; i < 3; i++) begin
            nerr += field_diff($sformatf("normal[%0d]", i), want.nrm[i], got.nrm[i]);
            nerr += field_diff($sformatf("point[%0d]", i), want.pt[i], got.pt[i]);
          end
        end
      end
    end
    errors <= rst ? 0 : errors + nerr;
    pending <= hit_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the ray/triangle intersection unit through a run of ray settings,
// with directed and random triangles and random stalls on both streams; the
// checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import rti_pkg::*;

  localparam longint     ONE      = 64'sd65536;
  localparam logic [2:0] CFG_NONE = 3'd7;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           errors;
  int           pending;

  longint ray_dir [3];
  longint ray_org [3];

  ray_triangle_intersect i_dut (.*);

  rti_checker i_chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

  // result side: random stalls, mostly short, a few long
  initial begin
    int len;
    forever begin
      @(posedge clk);
      len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 4) : $urandom_range(20, 80);
      m_axis_tready <= ($urandom_range(0, 2) != 0);
      repeat (len - 1) @(posedge clk);
    end
  end

  function automatic longint srnd(int bits);
    return longint'($urandom_range(0, (1 << bits) - 1)) - (64'sd1 << (bits - 1));
  endfunction

  task automatic send_beat(logic [287:0] d, logic sor);
    int r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= sor;
    do @(posedge clk); while (!s_axis_tready);
    r = $urandom_range(0, 99);
    if (r >= 50) begin
      s_axis_tvalid <= 1'b0;
      repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(20, 200)) @(posedge clk);
    end
  endtask

  // triangle whose point (u, v) sits at distance t0 along the ray
  task automatic send_tri(longint t0, longint u, longint v, longint a0, longint a1,
                          longint a2, longint b0, longint b1, longint b2, logic sor);
    longint a [3], b [3], v1;
    logic [287:0] d;
    a[0] = a0; a[1] = a1; a[2] = a2;
    b[0] = b0; b[1] = b1; b[2] = b2;
    for (int i = 0; i < 3; i++) begin
      v1 = ray_org[i] + ((ray_dir[i] * t0) >>> 16) - ((u * a[i]) >>> 16) - ((v * b[i]) >>> 16);
      d[32*i +: 32] = v1[31:0];
      d[96 + 32*i +: 32] = 32'(v1 + a[i]);
      d[192 + 32*i +: 32] = 32'(v1 + b[i]);
    end
    send_beat(d, sor);
  endtask

  task automatic send_noise(logic [31:0] w, logic sor);
    send_beat({9{w}}, sor);
  endtask

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    if (idx <= CFG_DIR_Z) cfg_data[31:18] <= 14'($urandom);
    if (idx == CFG_MAX_DIST) cfg_data[31] <= 1'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DIR_X: ray_dir[0] = longint'($signed(val[17:0]));
      CFG_DIR_Y: ray_dir[1] = longint'($signed(val[17:0]));
      CFG_DIR_Z: ray_dir[2] = longint'($signed(val[17:0]));
      CFG_ORG_X: ray_org[0] = longint'($signed(val[31:0]));
      CFG_ORG_Y: ray_org[1] = longint'($signed(val[31:0]));
      CFG_ORG_Z: ray_org[2] = longint'($signed(val[31:0]));
      default: ;
    endcase
  endtask

  task automatic set_ray(longint dx, longint dy, longint dz, longint ox, longint oy,
                         longint oz, longint md);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_ORG_X, ox);
    write_reg(CFG_ORG_Y, oy);
    write_reg(CFG_ORG_Z, oz);
    write_reg(CFG_MAX_DIST, md);
    write_reg(CFG_NONE, longint'($urandom));
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int bits;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 80) begin
        bits = ($urandom_range(0, 9) == 0) ? 27 : 21;
        send_tri(longint'($urandom_range(0, 1 << 23)) - ONE,
                 srnd(17) / 2 + ONE / 2, srnd(17) / 2 + ONE / 2,
                 srnd(bits), srnd(bits), srnd(bits), srnd(bits), srnd(bits), srnd(bits),
                 ($urandom_range(0, 7) == 0));
      end else begin
        send_beat({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom}, 1'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    ray_dir[0] = 0; ray_dir[1] = 0; ray_dir[2] = -ONE;
    ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset ray, straight down the minus z axis
    send_tri(10 * ONE, ONE / 4, ONE / 4, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 1'b1);
    send_tri(20 * ONE, ONE / 4, ONE / 4, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 1'b0);
    send_tri(5 * ONE, ONE / 3, ONE / 3, 0, 3 * ONE, 0, 2 * ONE, 0, ONE, 1'b0);
    send_tri(5 * ONE, ONE / 3, ONE / 3, 0, 3 * ONE, 0, 2 * ONE, 0, ONE, 1'b0);
    send_tri(8 * ONE, -ONE / 4, ONE / 4, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 1'b1);
    send_tri(8 * ONE, 5 * ONE / 4, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 1'b1);
    send_tri(8 * ONE, ONE / 4, -ONE / 4, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 1'b1);
    send_tri(8 * ONE, 3 * ONE / 5, 3 * ONE / 5, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 1'b1);
    send_tri(-3 * ONE, ONE / 4, ONE / 4, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 1'b1);
    send_tri(0, ONE / 4, ONE / 4, 4 * ONE, 0, 0, 0, 4 * ONE, 0, 1'b1);
    // ray lies in the triangle's plane, then a zero edge, then a tiny one
    send_tri(6 * ONE, ONE / 4, ONE / 4, 0, 0, ONE, ONE, 0, 0, 1'b1);
    send_tri(6 * ONE, 0, ONE / 4, 0, 0, 0, 0, 2 * ONE, 0, 1'b1);
    send_tri(6 * ONE, 0, 0, 1, 0, 0, 0, 1, 0, 1'b1);
    send_tri(ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b1);
    send_tri(ONE, ONE, 0, ONE, 0, 0, 0, ONE, 0, 1'b1);
    send_tri(ONE, 0, ONE, ONE, 0, 0, 0, ONE, 0, 1'b1);
    send_tri(30000 * ONE, ONE / 2, ONE / 2, 20000 * ONE, 0, 0, 0, 20000 * ONE, 0, 1'b1);
    send_noise(32'hFFFF_FFFF, 1'b1);
    send_noise(32'h7FFF_FFFF, 1'b0);
    send_noise(32'h8000_0000, 1'b1);
    send_noise(32'h0000_0000, 1'b0);
    send_beat({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000}, 1'b1);
    drain();
    random_phase(200);

    // hold off until everything is back before each new ray
    set_ray(ONE, 0, 0, -8 * ONE, 1, 2 * ONE, 64'h7FFF_FFFF);
    random_phase(230);
    set_ray(0, -ONE, 0, srnd(22), srnd(22), srnd(22), 0);
    random_phase(150);
    set_ray(46341, 0, 46341, srnd(24), srnd(24), srnd(24), 20 * ONE);
    random_phase(230);
    set_ray(0, 0, ONE, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF);
    random_phase(200);
    set_ray(0, 46341, -46341, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
            longint'($urandom_range(0, 32'h7FFF_FFFF)));
    random_phase(200);
    set_ray(37837, 37837, 37837, srnd(30), srnd(30), srnd(30), 64'h7FFF_FFFF);
    random_phase(230);
    set_ray(-ONE, 0, 0, srnd(20), srnd(20), srnd(20), 1);
    random_phase(150);
    set_ray(-37837, 37837, -37837, srnd(20), srnd(20), srnd(20),
            longint'($urandom_range(0, 32'h7FFF_FFFF)));
    random_phase(240);

    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
